### rtl/csd_pkg.sv
// ----------------------------------------------------------------------------
// csd_pkg
// Shared types and constants of the checksummed sentence decoder.
// ----------------------------------------------------------------------------
`default_nettype none
package csd_pkg;

  localparam int unsigned MAX_PAYLOAD = 76;
  localparam int unsigned COUNT_W = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_HEX1    = 3'd2,
    PH_HEX2    = 3'd3,
    PH_CR      = 3'd4,
    PH_LF      = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    MK_NONE = 3'd0,
    MK_CHA  = 3'd1,
    MK_ACC  = 3'd2,
    MK_REV  = 3'd3,
    MK_SHO  = 3'd4,
    MK_RES  = 3'd5
  } msg_kind_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_ERROR = 3'd1
  } event_code_t;

  // byte classified by the front end
  typedef enum logic [2:0] {
    OP_IGNORE = 3'd0,
    OP_START  = 3'd1,
    OP_PARSE  = 3'd2,
    OP_ERROR  = 3'd3,
    OP_END    = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       sum_ok;
  } work_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
  } result_t;

  function automatic logic [1:0] fields_needed(input logic [2:0] k);
    logic [1:0] n;
    unique case (k)
      MK_SHO:  n = 2'd2;
      MK_RES:  n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] type_letter(input logic [2:0] k, input logic [1:0] pos);
    logic [23:0] s;
    logic [7:0]  c;
    unique case (k)
      MK_CHA:  s = "CHA";
      MK_ACC:  s = "ACC";
      MK_REV:  s = "REV";
      MK_SHO:  s = "SHO";
      default: s = "RES";
    endcase
    unique case (pos)
      2'd1:    c = s[15:8];
      2'd2:    c = s[7:0];
      default: c = s[23:16];
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/csd_front.sv
// ----------------------------------------------------------------------------
// csd_front
// Framing state machine: checks delimiters, length, checksum and hands
// classified bytes to the parser.
// ----------------------------------------------------------------------------
`default_nettype none
module csd_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     rx_byte,
  output logic                w_valid,
  input  wire logic           w_ready,
  output csd_pkg::work_t      w_item
);
  import csd_pkg::*;

  phase_t               phase, phase_next;
  logic [COUNT_W-1:0]   payload_count, payload_count_next;
  logic [7:0]           running_xor, running_xor_next;
  logic                 payload_ended, payload_ended_next;
  logic [7:0]           received_sum, received_sum_next;
  logic [4:0]           hexv;
  logic                 fire;

  assign in_ready = w_ready;
  assign w_valid  = in_valid;
  assign fire     = in_valid && w_ready;

  always_comb begin
    hexv = 5'h10;
    if (rx_byte >= 8'h30 && rx_byte <= 8'h39) hexv = {1'b0, rx_byte[3:0]};
    else if ((rx_byte >= 8'h41 && rx_byte <= 8'h46) || (rx_byte >= 8'h61 && rx_byte <= 8'h66))
      hexv = {1'b0, rx_byte[3:0] + 4'd9};
  end

  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    running_xor_next   = running_xor;
    payload_ended_next = payload_ended;
    received_sum_next  = received_sum;
    w_item.op          = OP_IGNORE;
    w_item.data        = rx_byte;
    w_item.sum_ok      = (received_sum == running_xor);
    unique case (phase)
      PH_WAIT: begin
        if (rx_byte == CH_DOLLAR) begin
          w_item.op          = OP_START;
          phase_next         = PH_PAYLOAD;
          payload_count_next = '0;
          running_xor_next   = '0;
          payload_ended_next = 1'b0;
          received_sum_next  = '0;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_STAR) phase_next = PH_HEX1;
        else if (rx_byte == CH_CR || rx_byte == CH_DOLLAR ||
                 payload_count >= COUNT_W'(MAX_PAYLOAD)) begin
          w_item.op  = OP_ERROR;
          phase_next = PH_WAIT;
        end else begin
          payload_count_next = payload_count + 1'b1;
          if (!payload_ended) begin
            if (rx_byte == 8'h00) payload_ended_next = 1'b1;
            else begin
              running_xor_next = running_xor ^ rx_byte;
              w_item.op        = OP_PARSE;
            end
          end
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (hexv[4]) begin
          w_item.op  = OP_ERROR;
          phase_next = PH_WAIT;
        end else begin
          received_sum_next = {received_sum[3:0], hexv[3:0]};
          phase_next = (phase == PH_HEX1) ? PH_HEX2 : PH_CR;
        end
      end
      PH_CR: begin
        if (rx_byte == CH_CR) phase_next = PH_LF;
        else begin
          w_item.op  = OP_ERROR;
          phase_next = PH_WAIT;
        end
      end
      PH_LF: begin
        phase_next = PH_WAIT;
        if (rx_byte == CH_LF) w_item.op = OP_END;
        else w_item.op = OP_ERROR;
      end
      default: begin
        w_item.op  = OP_ERROR;
        phase_next = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      payload_count <= '0;
      running_xor   <= '0;
      payload_ended <= 1'b0;
      received_sum  <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      running_xor   <= running_xor_next;
      payload_ended <= payload_ended_next;
      received_sum  <= received_sum_next;
    end
  end

endmodule
`default_nettype wire

### rtl/csd_queue.sv
// ----------------------------------------------------------------------------
// csd_queue
// Two-entry queue between framing front end and parser.
// ----------------------------------------------------------------------------
`default_nettype none
module csd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_valid,
  output logic                s_ready,
  input  wire csd_pkg::work_t s_item,
  output logic                m_valid,
  input  wire logic           m_ready,
  output csd_pkg::work_t      m_item
);
  import csd_pkg::*;

  work_t      mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign s_ready = (count != 2'd2);
  assign m_valid = (count != 2'd0);
  assign m_item  = mem[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= s_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### rtl/csd_back.sv
// ----------------------------------------------------------------------------
// csd_back
// Payload parser and result register: type letters, fields and events.
// ----------------------------------------------------------------------------
`default_nettype none
module csd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           w_valid,
  output logic                w_ready,
  input  wire csd_pkg::work_t w_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          event_kind,
  output logic [31:0]         param_first,
  output logic [31:0]         param_second,
  output logic [31:0]         param_third
);
  import csd_pkg::*;

  logic [2:0]  pos, pos_next;
  logic [2:0]  kind, kind_next;
  logic [1:0]  fnum, fnum_next;
  logic [3:0]  flags, flags_next;
  logic [31:0] vals [3];
  logic [31:0] acc_next;
  logic        acc_we;
  logic        failed, failed_next;
  result_t     res;
  logic [7:0]  c;
  logic [31:0] v10, d;
  logic        blank, ok, fire, kind_valid;

  assign w_ready = !out_valid || out_ready;
  assign fire    = w_valid && w_ready;
  assign c       = w_item.data;
  assign blank   = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign kind_valid = (kind >= 3'd1) && (kind <= 3'd5);
  assign v10     = vals[fnum] * 32'd10;
  assign d       = {28'd0, c[3:0]};

  always_comb begin
    pos_next    = pos;
    kind_next   = kind;
    fnum_next   = fnum;
    flags_next  = flags;
    failed_next = failed;
    acc_we      = 1'b0;
    acc_next    = v10 + d;
    ok          = !failed && pos == 3'd4 && kind_valid && w_item.sum_ok &&
                  (flags[3] || (flags[2] && (fnum + 2'd1) == fields_needed(kind)));
    res = '0;
    unique case (w_item.op)
      OP_START: begin
        pos_next = '0; kind_next = '0; fnum_next = '0;
        flags_next = '0; failed_next = 1'b0;
      end
      OP_ERROR: res.kind = EV_ERROR;
      OP_END: begin
        if (ok) begin
          res.kind = kind + 3'd1;
          res.p0   = vals[0];
          if (kind >= MK_SHO) res.p1 = vals[1];
          if (kind == MK_RES) res.p2 = vals[2];
        end else res.kind = EV_ERROR;
      end
      OP_PARSE: begin
        if (!failed) begin
          if (pos == 3'd0) begin
            priority case (c)
              8'h43: kind_next = MK_CHA;
              8'h41: kind_next = MK_ACC;
              8'h52: kind_next = MK_REV;
              8'h53: kind_next = MK_SHO;
              default: failed_next = 1'b1;
            endcase
            pos_next = 3'd1;
          end else if (pos <= 3'd2) begin
            if (!kind_valid) failed_next = 1'b1;
            else begin
              if (kind == MK_REV && pos == 3'd2 && c == 8'h53) kind_next = MK_RES;
              else if (c != type_letter(kind, pos[1:0])) failed_next = 1'b1;
              pos_next = pos + 3'd1;
            end
          end else if (pos == 3'd3) begin
            if (c != CH_COMMA) failed_next = 1'b1;
            pos_next = 3'd4;
          end else if (!flags[3]) begin
            if (fnum > 2'd2 || !kind_valid) failed_next = 1'b1;
            else if (c >= 8'h30 && c <= 8'h39) begin
              acc_we   = 1'b1;
              acc_next = flags[1] ? v10 - d : v10 + d;
              flags_next = flags | 4'b0100;
            end else if (flags[2]) begin
              if ((fnum + 2'd1) == fields_needed(kind)) flags_next = 4'b1000;
              else if (c == CH_COMMA) begin
                fnum_next = fnum + 2'd1; flags_next = '0;
              end else failed_next = 1'b1;
            end else if (!flags[0] && blank) begin
            end else if (!flags[0] && c == CH_PLUS) flags_next = flags | 4'b0001;
            else if (!flags[0] && c == CH_MINUS) flags_next = flags | 4'b0011;
            else failed_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; kind <= '0; fnum <= '0; flags <= '0; failed <= 1'b0;
      vals[0] <= '0; vals[1] <= '0; vals[2] <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (fire) begin
        pos <= pos_next; kind <= kind_next; fnum <= fnum_next;
        flags <= flags_next; failed <= failed_next;
        if (w_item.op == OP_START) begin
          vals[0] <= '0; vals[1] <= '0; vals[2] <= '0;
        end else if (acc_we) vals[fnum] <= acc_next;
        out_valid    <= 1'b1;
        event_kind   <= res.kind;
        param_first  <= res.p0;
        param_second <= res.p1;
        param_third  <= res.p2;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/checksummed_sentence_decoder_top.sv
// path: each byte is classified by the framing stage and registered in the queue,
// then parsed from the queue head into the result register
// throughput: one byte per cycle, one result per byte, unless back-pressured
// reset: rst, synchronous, returns to hunting for the start delimiter
// ----------------------------------------------------------------------------
// checksummed_sentence_decoder_top
// Byte-stream sentence decoder with XOR checksum and decimal field parser.
// ----------------------------------------------------------------------------
`default_nettype none
module checksummed_sentence_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       event_kind,
  output logic [31:0]      param_first,
  output logic [31:0]      param_second,
  output logic [31:0]      param_third
);
  import csd_pkg::*;

  logic  f_valid, f_ready, b_valid, b_ready;
  work_t f_item, b_item;

  csd_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .rx_byte(rx_byte), .w_valid(f_valid), .w_ready(f_ready), .w_item(f_item)
  );

  csd_queue u_queue (
    .clk(clk), .rst(rst), .s_valid(f_valid), .s_ready(f_ready), .s_item(f_item),
    .m_valid(b_valid), .m_ready(b_ready), .m_item(b_item)
  );

  csd_back u_back (
    .clk(clk), .rst(rst), .w_valid(b_valid), .w_ready(b_ready), .w_item(b_item),
    .out_valid(out_valid), .out_ready(out_ready), .event_kind(event_kind),
    .param_first(param_first), .param_second(param_second), .param_third(param_third)
  );

endmodule
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the checksummed sentence decoder. A table of
// hand-written sentences and framing faults is followed by random sentences,
// noise and corrupted frames. Every accepted byte is run through a local
// decoder model. Each result transaction is compared with the oldest
// outstanding expectation. Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  import csd_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] p0;
    logic [31:0] p1;
    logic [31:0] p2;
  } outcome_t;

  typedef struct {
    logic [7:0] b;
    int         typed_kind;
  } stim_t;

  localparam int CYCLE_LIMIT = 250000;
  localparam int TOTAL_BYTES = 1650;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  event_kind;
  logic [31:0] param_first;
  logic [31:0] param_second;
  logic [31:0] param_third;

  outcome_t events_due[$];
  stim_t    stim_q[$];
  int       errors = 0;
  int       cycles = 0;
  int       stall_left = 0;
  int       n_msgs = 0;
  int       n_errs = 0;
  int       n_bytes = 0;
  bit       calm = 1'b0;

  // decoder model state
  phase_t      ph;
  int          pay_cnt;
  logic [7:0]  run_xor;
  bit          pay_ended;
  logic [7:0]  got_sum;
  int          ppos;
  msg_kind_t   mkind;
  int          fnum;
  logic [3:0]  fflags;
  logic [31:0] fval [3];
  bit          pfail;
  string       type_names [5] = '{"CHA", "ACC", "REV", "SHO", "RES"};

  always #2 clk = ~clk;

  checksummed_sentence_decoder_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .param_first(param_first),
    .param_second(param_second), .param_third(param_third)
  );

  function automatic void clear_sentence();
    pay_cnt = 0; run_xor = 8'h00; pay_ended = 1'b0; got_sum = 8'h00;
    ppos = 0; mkind = MK_NONE; fnum = 0; fflags = 4'h0; pfail = 1'b0;
    fval[0] = 32'h0; fval[1] = 32'h0; fval[2] = 32'h0;
  endfunction

  function automatic int needed(msg_kind_t k);
    return (k == MK_SHO) ? 2 : (k == MK_RES) ? 3 : 1;
  endfunction

  function automatic int hex_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    return -1;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    logic [31:0] v;
    logic [31:0] d;
    if (pfail) return;
    if (ppos == 0) begin
      case (c)
        "C": mkind = MK_CHA;
        "A": mkind = MK_ACC;
        "R": mkind = MK_REV;
        "S": mkind = MK_SHO;
        default: pfail = 1'b1;
      endcase
      ppos = 1;
      return;
    end
    if (ppos <= 2) begin
      if (mkind == MK_NONE) begin
        pfail = 1'b1;
        return;
      end
      if (mkind == MK_REV && ppos == 2 && c == "S") mkind = MK_RES;
      else if (c != type_names[int'(mkind) - 1][ppos]) pfail = 1'b1;
      ppos++;
      return;
    end
    if (ppos == 3) begin
      if (c != CH_COMMA) pfail = 1'b1;
      ppos = 4;
      return;
    end
    if (fflags[3]) return;
    if (fnum > 2 || mkind == MK_NONE) begin
      pfail = 1'b1;
      return;
    end
    if (c >= "0" && c <= "9") begin
      d = 32'(c - 8'h30);
      v = fval[fnum] * 32'd10;
      fval[fnum] = fflags[1] ? v - d : v + d;
      fflags[2] = 1'b1;
      return;
    end
    if (fflags[2]) begin
      if (fnum + 1 == needed(mkind)) fflags = 4'b1000;
      else if (c == CH_COMMA) begin
        fnum++;
        fflags = 4'h0;
      end else pfail = 1'b1;
      return;
    end
    if (!fflags[0]) begin
      if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return;
      if (c == CH_PLUS) begin
        fflags[0] = 1'b1;
        return;
      end
      if (c == CH_MINUS) begin
        fflags[1:0] = 2'b11;
        return;
      end
    end
    pfail = 1'b1;
  endfunction

  function automatic bit sentence_good();
    if (pfail || ppos != 4 || mkind == MK_NONE) return 1'b0;
    if (got_sum != run_xor) return 1'b0;
    if (fflags[3]) return 1'b1;
    return fflags[2] && (fnum + 1 == needed(mkind));
  endfunction

  function automatic outcome_t decode_byte(logic [7:0] c);
    outcome_t o;
    int h;
    o = '{EV_NONE, 32'h0, 32'h0, 32'h0};
    case (ph)
      PH_WAIT: if (c == CH_DOLLAR) begin
        clear_sentence();
        ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (c == CH_STAR) ph = PH_HEX1;
        else if (c == CH_CR || c == CH_DOLLAR || pay_cnt >= MAX_PAYLOAD) begin
          o.kind = EV_ERROR;
          ph = PH_WAIT;
        end else begin
          pay_cnt++;
          if (!pay_ended) begin
            if (c == 8'h00) pay_ended = 1'b1;
            else begin
              run_xor ^= c;
              parse_char(c);
            end
          end
        end
      end
      PH_HEX1, PH_HEX2: begin
        h = hex_of(c);
        if (h < 0) begin
          o.kind = EV_ERROR;
          ph = PH_WAIT;
        end else begin
          got_sum = {got_sum[3:0], 4'(h)};
          ph = (ph == PH_HEX1) ? PH_HEX2 : PH_CR;
        end
      end
      PH_CR: begin
        if (c == CH_CR) ph = PH_LF;
        else begin
          o.kind = EV_ERROR;
          ph = PH_WAIT;
        end
      end
      PH_LF: begin
        ph = PH_WAIT;
        if (c == CH_LF && sentence_good()) begin
          o.kind = 3'(mkind) + 3'd1;
          o.p0 = fval[0];
          if (mkind >= MK_SHO) o.p1 = fval[1];
          if (mkind == MK_RES) o.p2 = fval[2];
        end else o.kind = EV_ERROR;
      end
      default: begin
        o.kind = EV_ERROR;
        ph = PH_WAIT;
      end
    endcase
    return o;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  // queue a frame; "##" or "hh" after '*' becomes the checksum, one bit flipped if bad_sum
  function automatic void queue_frame(string s, int nul_at, int typed_kind, bit bad_sum);
    logic [7:0] q[$];
    logic [7:0] x;
    int star;
    int dollar;
    star = -1;
    dollar = -1;
    x = 8'h00;
    for (int i = 0; i < s.len(); i++) begin
      if (i == nul_at) q.push_back(8'h00);
      q.push_back(s[i]);
    end
    foreach (q[i]) if (dollar < 0 && q[i] == CH_DOLLAR) dollar = i;
    if (dollar >= 0)
      for (int i = dollar + 1; i < q.size(); i++) if (q[i] == CH_STAR) begin
        star = i;
        break;
      end
    if (star > 0 && star + 2 < q.size() && (q[star + 1] == "#" || q[star + 1] == "h")) begin
      for (int i = dollar + 1; i < star; i++) begin
        if (q[i] == 8'h00) break;
        x ^= q[i];
      end
      if (bad_sum) x ^= 8'(1 << $urandom_range(0, 7));
      q[star + 1] = hex_char(x[7:4], q[star + 1] == "h");
      q[star + 2] = hex_char(x[3:0], q[star + 2] == "h");
    end
    foreach (q[i]) stim_q.push_back('{q[i], (i == q.size() - 1) ? typed_kind : -1});
  endfunction

  function automatic string random_field();
    string f;
    int nd;
    f = "";
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
      f = {f, ($urandom_range(0, 1) != 0) ? " " : "\t"};
    case ($urandom_range(0, 3))
      0: f = {f, "-"};
      1: f = {f, "+"};
      default: ;
    endcase
    nd = ($urandom_range(0, 30) == 0) ? 0 : $urandom_range(1, 12);
    repeat (nd) f = {f, string'(8'h30 + 8'($urandom_range(0, 9)))};
    return f;
  endfunction

  function automatic void queue_random_frame();
    string s;
    int k;
    int nf;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, string'(8'($urandom_range(1, 255)))};
    k = $urandom_range(0, 4);
    s = {s, "$", type_names[k]};
    if ($urandom_range(0, 15) == 0) s[s.len() - 1 - $urandom_range(0, 2)] = 8'($urandom_range(65, 90));
    s = {s, ","};
    nf = (k == 3) ? 2 : (k == 4) ? 3 : 1;
    if ($urandom_range(0, 12) == 0) nf = $urandom_range(1, 3);
    for (int i = 0; i < nf; i++) s = {s, (i > 0) ? "," : "", random_field()};
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(33, 41)))};
    s = {s, ($urandom_range(0, 1) != 0) ? "*##" : "*hh", "\r\n"};
    if ($urandom_range(0, 12) == 0) s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
    queue_frame(s, ($urandom_range(0, 15) == 0) ? $urandom_range(2, 12) : -1, -1,
                $urandom_range(0, 15) == 0);
  endfunction

  // stimulus
  initial begin
    string longs;
    string fulls;
    stim_t st;
    outcome_t o;
    int total;
    ph = PH_WAIT;
    clear_sentence();
    longs = "$";
    repeat (MAX_PAYLOAD + 1) longs = {longs, "A"};
    fulls = "$CHA,1";
    repeat (MAX_PAYLOAD - 5) fulls = {fulls, " "};
    fulls = {fulls, "*##\r\n"};

    queue_frame("$CHA,12*##\r\n", -1, -1, 0);
    queue_frame("$ACC,-5*##\r\n", -1, -1, 0);
    queue_frame("$REV,+4294967295*##\r\n", -1, -1, 0);
    queue_frame("$SHO, 7,\t-8*##\r\n", -1, -1, 0);
    queue_frame("$RES,1,2,3xyz*##\r\n", -1, -1, 0);
    queue_frame("$RES,99999999999,0,-0*##\r\n", -1, -1, 0);
    queue_frame("\377\000x$CHA,5*hh\r\n", -1, -1, 0);
    queue_frame("$CHA,3Z*##\r\n", 6, -1, 0);
    queue_frame(fulls, -1, -1, 0);
    queue_frame("$CHA,1*00\r\n", -1, EV_ERROR, 0);
    queue_frame("$XYZ,1*##\r\n", -1, EV_ERROR, 0);
    queue_frame("$SHO,1*##\r\n", -1, EV_ERROR, 0);
    queue_frame("$CHA,-*##\r\n", -1, EV_ERROR, 0);
    queue_frame("$CHA,1\r", -1, EV_ERROR, 0);
    queue_frame("$CHA,$", -1, EV_ERROR, 0);
    queue_frame("$CHA,1*G", -1, EV_ERROR, 0);
    queue_frame("$CHA,1*##X", -1, EV_ERROR, 0);
    queue_frame("$CHA,1*##\rX", -1, EV_ERROR, 0);
    queue_frame(longs, -1, EV_ERROR, 0);
    total = TOTAL_BYTES;
    while (stim_q.size() < total) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 8)) stim_q.push_back('{8'($urandom_range(0, 255)), -1});
      else queue_random_frame();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0) begin
      st = stim_q.pop_front();
      calm = (stim_q.size() < 200);
      if (!calm && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      in_valid <= 1'b1;
      rx_byte <= st.b;
      do @(posedge clk); while (!in_ready);
      n_bytes++;
      o = decode_byte(st.b);
      if (st.typed_kind >= 0) o = '{3'(st.typed_kind), 32'h0, 32'h0, 32'h0};
      events_due.push_back(o);
    end
    in_valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d bytes sent, %0d message events and %0d error events checked",
             n_bytes, n_msgs, n_errs);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // result side: stalls and checking
  always @(posedge clk) begin
    outcome_t e;
    if (rst) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) begin
        if (events_due.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction: kind %0d", $time, event_kind);
        end else begin
          e = events_due.pop_front();
          if (e.kind == EV_ERROR) n_errs++;
          else if (e.kind != EV_NONE) n_msgs++;
          if (event_kind !== e.kind || param_first !== e.p0 ||
              param_second !== e.p1 || param_third !== e.p2) begin
            errors++;
            $display("%0t mismatch: expected %0d %h %h %h, actual %0d %h %h %h", $time,
                     e.kind, e.p0, e.p1, e.p2,
                     event_kind, param_first, param_second, param_third);
          end
        end
      end
      if (calm) out_ready <= 1'b1;
      else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
`default_nettype wire
